FILE: rtl/bclv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bclv_pkg: shared types and constants of the bytecode length validator
// Request and result layouts, opcode and fault codes, and the opcode length
// lookup used to find instruction boundaries.
// ----------------------------------------------------------------------------
package bclv_pkg;

  // Special opcodes and their length rules.
  localparam logic [7:0]  OP_ENTER    = 8'd45;
  localparam logic [7:0]  OP_SWITCH   = 8'd98;
  localparam int unsigned SWITCH_MUL  = 6;
  localparam int unsigned LEFT_W      = 11;

  // Kind of instruction whose length byte is still awaited.
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_ENTER  = 2'd1;
  localparam logic [1:0] KIND_SWITCH = 2'd2;

  // Enter carries its length byte at this offset from the opcode.
  localparam logic [2:0] ENTER_LEN_OFFSET = 3'd4;

  // Sticky fault codes.
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FIRST = 2'd1;
  localparam logic [1:0] FAULT_ZERO  = 2'd2;
  localparam logic [1:0] FAULT_TRUNC = 2'd3;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic       starts_instruction;
    logic [1:0] fault_kind;
    logic       done_res;
    logic       valid_res;
  } res_t;

  // Instruction length of a plain opcode; zero marks an illegal opcode.
  // Enter and switch are handled separately by the caller.
  function automatic logic [2:0] table_len(input logic [7:0] op);
    logic [2:0] len;
    if (op <= 8'd36)       len = 3'd1;
    else if (op == 8'd37)  len = 3'd2;
    else if (op == 8'd38)  len = 3'd3;
    else if (op == 8'd39)  len = 3'd4;
    else if (op <= 8'd41)  len = 3'd5;
    else if (op <= 8'd43)  len = 3'd1;
    else if (op == 8'd44)  len = 3'd4;
    else if (op == 8'd45)  len = 3'd0;
    else if (op == 8'd46)  len = 3'd3;
    else if (op <= 8'd51)  len = 3'd1;
    else if (op <= 8'd62)  len = 3'd2;
    else if (op == 8'd63)  len = 3'd1;
    else if (op <= 8'd66)  len = 3'd2;
    else if (op <= 8'd92)  len = 3'd3;
    else if (op <= 8'd97)  len = 3'd4;
    else if (op == 8'd98)  len = 3'd0;
    else if (op <= 8'd100) len = 3'd1;
    else if (op <= 8'd104) len = 3'd2;
    else if (op <= 8'd126) len = 3'd1;
    else                   len = 3'd0;
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bytecode_length_validator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bytecode_length_validator: streaming instruction boundary checker
// The result of a request appears in the output register in the cycle after it is taken.
// Throughput: one byte per cycle; a request is taken whenever the output
// register is empty or being drained in the same cycle.
// Reset clears the scan state and empties the output register; the scan state
// also returns to its reset values after every request flagged as last byte.
// ----------------------------------------------------------------------------
module bytecode_length_validator (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  output logic            req_stall,
  input  wire bclv_pkg::req_t req_data,
  output logic            res_valid,
  input  wire             res_stall,
  output bclv_pkg::res_t  res_data
);
  import bclv_pkg::*;

  // Scan state.
  logic [LEFT_W-1:0] bytes_left, bytes_left_next;
  logic [2:0]        offset_in_instr, offset_in_instr_next;
  logic [1:0]        pending_kind, pending_kind_next;
  logic              seen_first, seen_first_next;
  logic [1:0]        fault_state, fault_state_next;

  logic              accept;
  res_t              res_next;
  logic [2:0]        op_len;
  logic [LEFT_W-1:0] switch_left;

  // The output register parts the two sides; stall only while it is held.
  assign req_stall = res_valid & res_stall;
  assign accept    = req_valid & ~req_stall;

  assign op_len      = table_len(req_data.code_byte);
  assign switch_left = LEFT_W'(SWITCH_MUL) * LEFT_W'(req_data.code_byte);

  // Boundary tracking and verdict for one byte.
  always_comb begin
    bytes_left_next      = bytes_left;
    offset_in_instr_next = offset_in_instr;
    pending_kind_next    = pending_kind;
    seen_first_next      = seen_first;
    fault_state_next     = fault_state;
    res_next             = '0;

    if (fault_state == FAULT_NONE) begin
      priority if (pending_kind == KIND_ENTER) begin
        offset_in_instr_next = offset_in_instr + 3'd1;
        if (offset_in_instr_next == ENTER_LEN_OFFSET) begin
          bytes_left_next      = LEFT_W'(req_data.code_byte);
          pending_kind_next    = KIND_PLAIN;
          offset_in_instr_next = '0;
        end
      end else if (pending_kind == KIND_SWITCH) begin
        bytes_left_next      = switch_left;
        pending_kind_next    = KIND_PLAIN;
        offset_in_instr_next = '0;
      end else if (bytes_left != '0) begin
        bytes_left_next = bytes_left - LEFT_W'(1);
      end else begin
        res_next.starts_instruction = 1'b1;
        seen_first_next             = 1'b1;
        priority if (!seen_first && req_data.code_byte != OP_ENTER) begin
          fault_state_next = FAULT_FIRST;
        end else if (req_data.code_byte == OP_ENTER) begin
          pending_kind_next    = KIND_ENTER;
          offset_in_instr_next = '0;
        end else if (req_data.code_byte == OP_SWITCH) begin
          pending_kind_next    = KIND_SWITCH;
          offset_in_instr_next = '0;
        end else if (op_len == 3'd0) begin
          fault_state_next = FAULT_ZERO;
        end else begin
          bytes_left_next = LEFT_W'(op_len - 3'd1);
        end
      end
    end

    // A cut-off instruction is only detectable on the final byte.
    if (req_data.last_byte) begin
      res_next.done_res = 1'b1;
      if (fault_state_next == FAULT_NONE &&
          (bytes_left_next != '0 || pending_kind_next != KIND_PLAIN)) begin
        fault_state_next = FAULT_TRUNC;
      end
      res_next.valid_res = (fault_state_next == FAULT_NONE);
    end
    res_next.fault_kind = fault_state_next;
  end

  // Scan state update; the final byte sends the scan back to reset.
  always_ff @(posedge clk) begin
    if (rst || (accept && req_data.last_byte)) begin
      bytes_left      <= '0;
      offset_in_instr <= '0;
      pending_kind    <= KIND_PLAIN;
      seen_first      <= 1'b0;
      fault_state     <= FAULT_NONE;
    end else if (accept) begin
      bytes_left      <= bytes_left_next;
      offset_in_instr <= offset_in_instr_next;
      pending_kind    <= pending_kind_next;
      seen_first      <= seen_first_next;
      fault_state     <= fault_state_next;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_next;
    end
  end

  // A held fault survives every later byte until the final one.
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && fault_state != FAULT_NONE && !req_data.last_byte
    |=> fault_state == $past(fault_state))
    else $error("held fault changed before the final byte");

  // The final byte leaves the scan in its reset state.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && req_data.last_byte
    |=> bytes_left == '0 && pending_kind == KIND_PLAIN && !seen_first &&
        fault_state == FAULT_NONE && offset_in_instr == '0)
    else $error("scan state not cleared after final byte");

  // The offset counter only runs while an enter awaits its length byte.
  a_offset_idle: assert property (@(posedge clk) disable iff (rst)
    pending_kind != KIND_ENTER |-> offset_in_instr == '0)
    else $error("offset counter running outside an enter");

  // A verdict is only reported together with the final byte.
  a_verdict_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.done_res |-> !res_data.valid_res)
    else $error("verdict reported without final byte");

endmodule
`default_nettype wire

FILE: sim/bytecode_length_validator_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bytecode_length_validator_tb: self-checking bench for the length validator
// Streams whole bytecode programs, well-formed ones with random content and
// cut-off, illegal or noisy ones, through the request channel. Every result
// is checked field by field against a scan model kept in the bench, under
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module bytecode_length_validator_tb;
  import bclv_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_data;

  bytecode_length_validator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // Requests waiting to be offered, and the verdicts owed by the block.
  req_t       bytes_to_send [$];
  res_t       verdicts_due [$];
  logic [7:0] prog_bytes [$];

  // Scan state of the bench's own model.
  logic [10:0] operand_left = '0;
  logic [2:0]  enter_offset = '0;
  logic [1:0]  awaiting     = KIND_PLAIN;
  logic        opened       = 1'b0;
  logic [1:0]  held_fault   = FAULT_NONE;

  // Handshake bookkeeping and pacing.
  logic req_taken = 1'b0;
  logic res_taken = 1'b0;
  int   send_gap_max = 14;
  int   recv_gap_max = 14;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   hold_left = 0;
  bit   long_hold_req = 1'b0;

  // Statistics.
  int   mismatch_count = 0;
  int   bytes_queued = 0;
  int   programs_queued = 0;
  int   results_checked = 0;
  int   clean_verdicts = 0;
  int   fault_tally [4];
  res_t want;

  // Length of a plain opcode; zero means the opcode is illegal.
  function automatic int opcode_length(input logic [7:0] op);
    if (op > 8'd126) return 0;
    if (op > 8'd104) return 1;
    if (op > 8'd100) return 2;
    if (op > 8'd98)  return 1;
    if (op == 8'd98) return 0;
    if (op > 8'd92)  return 4;
    if (op > 8'd66)  return 3;
    if (op > 8'd63)  return 2;
    if (op == 8'd63) return 1;
    if (op > 8'd51)  return 2;
    if (op > 8'd46)  return 1;
    if (op == 8'd46) return 3;
    if (op == 8'd45) return 0;
    if (op == 8'd44) return 4;
    if (op > 8'd41)  return 1;
    if (op > 8'd39)  return 5;
    if (op > 8'd36)  return int'(op) - 35;
    return 1;
  endfunction

  // Advance the scan by one byte and return the verdict the block must give.
  function automatic res_t scan_byte(input req_t r);
    res_t o;
    int   len;
    o = '0;
    if (held_fault == FAULT_NONE) begin
      if (awaiting == KIND_ENTER) begin
        enter_offset = enter_offset + 3'd1;
        if (enter_offset == ENTER_LEN_OFFSET) begin
          operand_left = {3'b000, r.code_byte};
          awaiting = KIND_PLAIN;
          enter_offset = '0;
        end
      end else if (awaiting == KIND_SWITCH) begin
        operand_left = 11'(SWITCH_MUL * r.code_byte);
        awaiting = KIND_PLAIN;
        enter_offset = '0;
      end else if (operand_left != '0) begin
        operand_left = operand_left - 11'd1;
      end else begin
        o.starts_instruction = 1'b1;
        if (!opened && r.code_byte != OP_ENTER) begin
          held_fault = FAULT_FIRST;
        end else if (r.code_byte == OP_ENTER) begin
          awaiting = KIND_ENTER;
          enter_offset = '0;
        end else if (r.code_byte == OP_SWITCH) begin
          awaiting = KIND_SWITCH;
          enter_offset = '0;
        end else begin
          len = opcode_length(r.code_byte);
          if (len == 0) held_fault = FAULT_ZERO;
          else operand_left = 11'(len - 1);
        end
        opened = 1'b1;
      end
    end
    if (r.last_byte) begin
      o.done_res = 1'b1;
      if (held_fault == FAULT_NONE && (operand_left != '0 || awaiting != KIND_PLAIN))
        held_fault = FAULT_TRUNC;
      o.valid_res = (held_fault == FAULT_NONE);
    end
    o.fault_kind = held_fault;
    if (r.last_byte) begin
      operand_left = '0;
      enter_offset = '0;
      awaiting = KIND_PLAIN;
      opened = 1'b0;
      held_fault = FAULT_NONE;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at result %0d: %s", results_checked, msg);
  endtask

  // Append one byte to the program under construction.
  task automatic add_byte(input logic [7:0] b);
    prog_bytes = {prog_bytes, b};
  endtask

  // Move the program under construction into the request queue, flagging its end.
  task automatic flush_program();
    req_t r;
    while (prog_bytes.size() != 0) begin
      r.code_byte = prog_bytes.pop_front();
      r.last_byte = (prog_bytes.size() == 0);
      bytes_to_send = {bytes_to_send, r};
      bytes_queued++;
    end
    programs_queued++;
  endtask

  // Mostly tiny counts, now and then a random or the largest one.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) return 255;
    if (r < 3) return $urandom_range(0, 255);
    return $urandom_range(0, 4);
  endfunction

  task automatic append_enter();
    int frame;
    frame = pick_count();
    add_byte(OP_ENTER);
    repeat (3) add_byte(8'($urandom));
    add_byte(8'(frame));
    repeat (frame) add_byte(8'($urandom));
  endtask

  task automatic append_instruction();
    int         pick;
    int         cases;
    int         len;
    logic [7:0] op;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      append_enter();
    end else if (pick == 1) begin
      cases = pick_count();
      add_byte(OP_SWITCH);
      add_byte(8'(cases));
      repeat (6 * cases) add_byte(8'($urandom));
    end else begin
      op = 8'($urandom_range(0, 126));
      if ($urandom_range(0, 29) == 0) op = 8'($urandom_range(127, 255));
      if (op == OP_ENTER || op == OP_SWITCH) op = 8'h00;
      len = opcode_length(op);
      add_byte(op);
      if (len > 1) repeat (len - 1) add_byte(8'($urandom));
    end
  endtask

  // Random program: mostly well formed, some cut short, some pure noise.
  task automatic build_random_program();
    int shape;
    int count;
    int keep;
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      count = $urandom_range(1, 12);
      repeat (count) add_byte(8'($urandom));
    end else begin
      append_enter();
      count = $urandom_range(0, 6);
      repeat (count) append_instruction();
      if (shape < 5 && prog_bytes.size() > 1) begin
        keep = $urandom_range(1, prog_bytes.size() - 1);
        while (prog_bytes.size() > keep) void'(prog_bytes.pop_back());
      end
    end
    flush_program();
  endtask

  task automatic drain_requests();
    while (bytes_to_send.size() != 0 || req_valid) @(posedge clk);
  endtask

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge; predict and check.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      res_taken <= res_valid && !res_stall;
      if (req_valid && !req_stall) verdicts_due = {verdicts_due, scan_byte(req_data)};
      if (res_valid && !res_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = verdicts_due.pop_front();
          if (res_data.starts_instruction != want.starts_instruction)
            report_mismatch($sformatf("starts_instruction got %0d expected %0d",
                                      res_data.starts_instruction, want.starts_instruction));
          if (res_data.fault_kind != want.fault_kind)
            report_mismatch($sformatf("fault_kind got %0d expected %0d",
                                      res_data.fault_kind, want.fault_kind));
          if (res_data.done_res != want.done_res)
            report_mismatch($sformatf("done_res got %0d expected %0d",
                                      res_data.done_res, want.done_res));
          if (res_data.valid_res != want.valid_res)
            report_mismatch($sformatf("valid_res got %0d expected %0d",
                                      res_data.valid_res, want.valid_res));
          if (want.done_res) begin
            if (want.valid_res) clean_verdicts++;
            else fault_tally[want.fault_kind]++;
          end
        end
        results_checked++;
      end
    end
  end

  // Request driver: offers queued bytes with a random gap after each one.
  always @(negedge clk) begin
    if (!rst) begin
      if (req_valid && req_taken) send_wait = $urandom_range(0, send_gap_max);
      if (req_valid && !req_taken) begin
        req_valid <= 1'b1;
      end else if (send_wait != 0) begin
        send_wait--;
        req_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        req_data <= bytes_to_send.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each result, plus one long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= (hold_left != 0);
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 80;
        res_stall <= 1'b1;
      end else begin
        if (res_taken) recv_wait = $urandom_range(0, recv_gap_max);
        else if (recv_wait != 0) recv_wait--;
        res_stall <= (recv_wait != 0);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    for (int k = 0; k < 4; k++) fault_tally[k] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: first opcode not enter, minimal enter, enter cut off at once.
    add_byte(8'h00);
    flush_program();
    prog_bytes = '{OP_ENTER, 8'h00, 8'h00, 8'h00, 8'h00};
    flush_program();
    add_byte(OP_ENTER);
    flush_program();
    // Empty switch, then an illegal opcode whose fault sticks to the end.
    prog_bytes = '{OP_ENTER, 8'h01, 8'h80, 8'hFF, 8'h00, OP_SWITCH, 8'h00,
                   8'hFF, 8'h07, 8'h08};
    flush_program();
    // Empty switch followed by the highest legal opcode, ending cleanly.
    prog_bytes = '{OP_ENTER, 8'h55, 8'hAA, 8'h7F, 8'h00, OP_SWITCH, 8'h00, 8'h7E};
    flush_program();

    // Sender pause: let every directed verdict come back.
    drain_requests();
    while (verdicts_due.size() != 0) @(posedge clk);

    // Random with gaps on both sides, and a long receiver hold-off midway.
    while (bytes_queued < 600) build_random_program();
    long_hold_req = 1'b1;
    drain_requests();

    // Back to back with no idling.
    send_gap_max = 0;
    recv_gap_max = 0;
    while (bytes_queued < 1000) build_random_program();
    drain_requests();

    // Gaps again on both sides.
    send_gap_max = 14;
    recv_gap_max = 14;
    while (bytes_queued < 1500) build_random_program();
    drain_requests();
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Scanned %0d bytes in %0d programs, %0d results checked.",
             bytes_queued, programs_queued, results_checked);
    $display("Verdicts: %0d clean, %0d first-not-enter, %0d illegal opcode, %0d cut off.",
             clean_verdicts, fault_tally[FAULT_FIRST], fault_tally[FAULT_ZERO],
             fault_tally[FAULT_TRUNC]);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/bclv_pkg.sv
rtl/bytecode_length_validator.sv
sim/bytecode_length_validator_tb.sv
